[rtl/dscg_pkg.sv]
// ----------------------------------------------------------------------------
// dscg_pkg : shared definitions for the decaying sine click generator
// Sample and sine table widths, register indices, stage types and the
// elaboration-time builder for the quarter-wave sine table.
// ----------------------------------------------------------------------------
package dscg_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int SINE_INDEX_BITS = 10;
  localparam int SINE_FULL       = 1 << SINE_INDEX_BITS;
  localparam int SINE_DEPTH      = SINE_FULL + 1;
  localparam int SINE_ADDR_BITS  = SINE_INDEX_BITS + 1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int CFG_DATA_BITS  = 31;
  localparam int CFG_INDEX_BITS = 3;

  // register indices of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BEAT_STEP    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ACCENT_STEP  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BEAT_AMP     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ACCENT_AMP   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY        = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLICK_LENGTH = 3'd5;

  typedef logic [14:0] sine_rom_t [SINE_DEPTH];

  // sample item after the first stage, without the table word
  typedef struct packed {
    logic                          active;
    logic                          neg;
    logic [15:0]                   gain;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } dscg_s1_t;

  // restoring division, truncating; used only while the table is built
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(k/2^N * pi/2) in Q15: Taylor series to x^13 in Q30, round half up, clamp
  function automatic sine_rom_t sine_rom_build();
    sine_rom_t       rom;
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint          e;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      x    = (longint'(k) * HALF_PI_Q30) >> SINE_INDEX_BITS;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = div_u64(term, 64'((2 * n) * (2 * n + 1)));
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      e = (sum + 16384) >>> 15;
      if (e > 32767) begin
        e = 32767;
      end
      rom[k] = e[14:0];
    end
    return rom;
  endfunction

endpackage

[rtl/dscg_sine_rom.sv]
// ----------------------------------------------------------------------------
// dscg_sine_rom : quarter-wave sine table with registered read
// Folds the phase into a table address and returns the unsigned Q0.15 word.
// ----------------------------------------------------------------------------
module dscg_sine_rom
  import dscg_pkg::*;
(
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] phase,
  output logic [14:0] rom_q
);

  localparam sine_rom_t SINE_ROM = sine_rom_build();

  logic [SINE_INDEX_BITS-1:0] k;
  logic [SINE_ADDR_BITS-1:0]  addr;

  // mirror the index in quadrants one and three
  always_comb begin
    k = phase[29 -: SINE_INDEX_BITS];
    if (phase[30]) begin
      addr = SINE_ADDR_BITS'(SINE_FULL) - {1'b0, k};
    end else begin
      addr = {1'b0, k};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rom_q <= SINE_ROM[addr];
    end
  end

endmodule

[rtl/dscg_voice.sv]
// ----------------------------------------------------------------------------
// dscg_voice : configuration registers and oscillator state
// Restarts the voice on a strike and advances phase, gain and count per sample.
// ----------------------------------------------------------------------------
module dscg_voice
  import dscg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                      strike_acc,
  input  logic                      sample_acc,
  input  logic                      accent,
  output logic [31:0]               phase,
  output logic [15:0]               gain,
  output logic                      live
);

  logic [30:0] beat_step_r;
  logic [30:0] accent_step_r;
  logic [14:0] beat_amp_r;
  logic [14:0] accent_amp_r;
  logic [15:0] decay_r;
  logic [15:0] click_length_r;

  logic [31:0] phase_r, phase_nxt;
  logic [31:0] step_r, step_nxt;
  logic [15:0] gain_r, gain_nxt;
  logic [15:0] left_r, left_nxt;
  logic [31:0] decay_prod;
  logic [15:0] left_dec;

  assign decay_prod = gain_r * decay_r;
  assign left_dec   = left_r - 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    gain_nxt  = gain_r;
    left_nxt  = left_r;
    if (strike_acc) begin
      phase_nxt = '0;
      step_nxt  = {1'b0, (accent ? accent_step_r : beat_step_r)};
      gain_nxt  = {1'b0, (accent ? accent_amp_r : beat_amp_r)};
      left_nxt  = click_length_r;
    end else if (sample_acc && live) begin
      phase_nxt = phase_r + step_r;
      gain_nxt  = decay_prod[31:16];
      left_nxt  = left_dec;
      // end of click: silence the voice
      if (left_dec == '0) begin
        phase_nxt = '0;
        gain_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_step_r    <= 31'd89478485;
      accent_step_r  <= 31'd134217728;
      beat_amp_r     <= 15'd16384;
      accent_amp_r   <= 15'd26214;
      decay_r        <= 16'd65222;
      click_length_r <= 16'd1440;
      phase_r        <= '0;
      step_r         <= '0;
      gain_r         <= '0;
      left_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BEAT_STEP:    beat_step_r    <= cfg_wdata;
          CFG_ACCENT_STEP:  accent_step_r  <= cfg_wdata;
          CFG_BEAT_AMP:     beat_amp_r     <= cfg_wdata[14:0];
          CFG_ACCENT_AMP:   accent_amp_r   <= cfg_wdata[14:0];
          CFG_DECAY:        decay_r        <= cfg_wdata[15:0];
          CFG_CLICK_LENGTH: click_length_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      gain_r  <= gain_nxt;
      left_r  <= left_nxt;
    end
  end

  assign phase = phase_r;
  assign gain  = gain_r;
  assign live  = (left_r != '0);

endmodule

[rtl/dscg_mix.sv]
// ----------------------------------------------------------------------------
// dscg_mix : click product, rounding, mix and saturation
// Second stage holds gain times sine; output stage adds and clamps.
// ----------------------------------------------------------------------------
module dscg_mix
  import dscg_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  input  dscg_s1_t                      s1,
  input  logic [14:0]                   rom_q,
  output logic                          s1_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right
);

  localparam int          SHR = (SAMPLE_BITS >= 31) ? 0 : 31 - SAMPLE_BITS;
  localparam int          SHL = (SAMPLE_BITS >= 31) ? SAMPLE_BITS - 31 : 0;
  localparam logic [33:0] RND = (SAMPLE_BITS >= 31) ? 34'd0 :
                                34'(64'd1 << (30 - SAMPLE_BITS));
  localparam int          SUM_W = SAMPLE_BITS + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic                          s2_valid_r;
  logic                          s2_active_r;
  logic                          s2_neg_r;
  logic [30:0]                   s2_mag_r;
  logic signed [SAMPLE_BITS-1:0] s2_left_r;
  logic signed [SAMPLE_BITS-1:0] s2_right_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r, out_left_nxt;
  logic signed [SAMPLE_BITS-1:0] out_right_r, out_right_nxt;

  logic                          s2_ready;
  logic [33:0]                   rounded;
  logic [33:0]                   cmag_w;
  logic signed [SUM_W-1:0]       click;
  logic signed [SUM_W-1:0]       left_sum;
  logic signed [SUM_W-1:0]       right_sum;

  function automatic logic signed [SAMPLE_BITS-1:0] clamp(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  assign s2_ready = !out_valid_r || out_ready;
  assign s1_ready = !s2_valid_r || s2_ready;

  // round half up in magnitude, then reapply the sign
  always_comb begin
    rounded = {3'b0, s2_mag_r} + RND;
    cmag_w  = (rounded >> SHR) << SHL;
    click   = '0;
    if (s2_active_r) begin
      click = s2_neg_r ? -$signed({1'b0, cmag_w[SAMPLE_BITS:0]})
                       :  $signed({1'b0, cmag_w[SAMPLE_BITS:0]});
    end
    left_sum      = SUM_W'(s2_left_r) + click;
    right_sum     = SUM_W'(s2_right_r) + click;
    out_left_nxt  = clamp(left_sum);
    out_right_nxt = clamp(right_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s2_valid_r <= s1_valid;
      end
      if (s2_ready) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s2_active_r <= s1.active;
      s2_neg_r    <= s1.neg;
      s2_mag_r    <= s1.gain * rom_q;
      s2_left_r   <= s1.left;
      s2_right_r  <= s1.right;
    end
    if (s2_ready) begin
      out_left_r  <= out_left_nxt;
      out_right_r <= out_right_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

endmodule

[rtl/decaying_sine_click_generator_unit.sv]
// ----------------------------------------------------------------------------
// decaying_sine_click_generator_unit : metronome click mixer
// Adds a decaying sine click to a stereo stream of signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_kind 0 is a strike item that restarts
//   the click voice (in_accent picks accent or plain pitch and gain) and gives
//   no result; in_kind 1 is a stereo sample item that gives exactly one result.
//   Result channel (out_valid/out_ready): the mixed, saturated stereo pair, in
//   the order the sample items came in.
//   Configuration: cfg_we with cfg_index and cfg_wdata writes one register at
//   once; write only while the block is idle. Unused indices are ignored.
//   Throughput: one item per cycle, strikes and samples alike, while no stage
//   stalls. A sample item passes through the table read, gain multiply, and
//   mix and clamp registers in that order before out_valid rises.
//   Stall: each stage holds while the next is full, so items keep being taken
//   until all three stages hold a sample; in_ready then follows out_ready.
//   Reset (rst_n, synchronous): registers return to their defaults, the voice
//   goes silent and the pipeline empties.
// ----------------------------------------------------------------------------
module decaying_sine_click_generator_unit
  import dscg_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic                          in_accent,
  input  logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [SAMPLE_BITS-1:0] in_right_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out
);

  logic        strike_acc;
  logic        sample_acc;
  logic [31:0] phase;
  logic [15:0] gain;
  logic        live;
  logic [14:0] rom_q;
  logic        s1_ready;
  logic        s1_valid_r;
  dscg_s1_t    s1_r;

  // first stage may load when empty or when its item moves on
  assign in_ready   = !s1_valid_r || s1_ready;
  assign strike_acc = in_valid && in_ready && !in_kind;
  assign sample_acc = in_valid && in_ready && in_kind;

  // oscillator state advances as each item is taken
  dscg_voice u_voice (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .strike_acc (strike_acc),
    .sample_acc (sample_acc),
    .accent     (in_accent),
    .phase      (phase),
    .gain       (gain),
    .live       (live)
  );

  // table word is read from the phase before it advances
  dscg_sine_rom u_rom (
    .clk   (clk),
    .load  (in_ready),
    .phase (phase),
    .rom_q (rom_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= sample_acc;
    end
  end

  // capture the sample with the gain and sign that apply to it
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_r.active <= live;
      s1_r.neg    <= phase[31];
      s1_r.gain   <= gain;
      s1_r.left   <= in_left_in;
      s1_r.right  <= in_right_in;
    end
  end

  dscg_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1        (s1_r),
    .rom_q     (rom_q),
    .s1_ready  (s1_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_left  (out_left_out),
    .out_right (out_right_out)
  );

endmodule
